/* rtl/atte_pkg.sv */
// ----------------------------------------------------------------------------
// ANSI text terminal engine package
// Shared widths, command codes, character codes, result type and colour map.
// ----------------------------------------------------------------------------
package atte_pkg;

	localparam int MaxArgs    = 8;
	localparam int MaxColumns = 128;
	localparam int MaxRows    = 64;

	localparam int ArgIdxW = $clog2(MaxArgs);
	localparam int ColW    = $clog2(MaxColumns);
	localparam int RowW    = $clog2(MaxRows);
	localparam int ColsW   = ColW + 1;
	localparam int RowsW   = RowW + 1;

	localparam int CmdW   = 2;
	localparam int IdxW   = 13;
	localparam int CntW   = 14;
	localparam int ValW   = 16;
	localparam int ArgW   = 16;
	localparam int MacW   = 25;

	localparam logic [ArgW-1:0] ArgMax = 16'hFFFF;
	localparam logic [15:0] ResetAttribute = 16'h1700;
	localparam logic [15:0] BoldAdd = 16'h0800;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_COLUMNS = 2'd0;
	localparam logic [1:0] REG_ROWS    = 2'd1;
	localparam logic [1:0] REG_DEFATTR = 2'd2;
	localparam logic [1:0] REG_ENABLE  = 2'd3;

	// Character codes.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_LBR   = 8'h5B;
	localparam logic [7:0] CH_UP    = 8'h41;
	localparam logic [7:0] CH_DOWN  = 8'h42;
	localparam logic [7:0] CH_RIGHT = 8'h43;
	localparam logic [7:0] CH_LEFT  = 8'h44;
	localparam logic [7:0] CH_ED    = 8'h4A;
	localparam logic [7:0] CH_EL    = 8'h4B;
	localparam logic [7:0] CH_POS   = 8'h66;
	localparam logic [7:0] CH_SGR   = 8'h6D;
	localparam logic [7:0] CH_SAVE  = 8'h73;
	localparam logic [7:0] CH_REST  = 8'h75;

	// Parser modes.
	localparam logic [1:0] MODE_TEXT = 2'd0;
	localparam logic [1:0] MODE_ESC  = 2'd1;
	localparam logic [1:0] MODE_CSI  = 2'd2;

	typedef enum logic [CmdW-1:0] {
		CMD_UPDATE = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_FILL   = 2'd2,
		CMD_SCROLL = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t            cmd;
		logic [IdxW-1:0] idx;
		logic [CntW-1:0] cnt;
		logic [ValW-1:0] val;
	} res_t;

	// ANSI colour number to text-mode colour nibble.
	localparam logic [3:0] COLOUR_MAP [8] = '{4'd0, 4'd4, 4'd2, 4'd6, 4'd1, 4'd5, 4'd3, 4'd7};

endpackage

/* rtl/atte_in_if.sv */
// ----------------------------------------------------------------------------
// Input byte channel
// Valid/ready channel carrying one character byte per beat.
// ----------------------------------------------------------------------------
interface atte_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;

	modport source(output valid, output char_byte, input ready);
	modport sink(input valid, input char_byte, output ready);
endinterface

/* rtl/atte_out_if.sv */
// ----------------------------------------------------------------------------
// Output command channel
// Valid/ready channel carrying one cell-store command per beat.
// ----------------------------------------------------------------------------
interface atte_out_if;
	import atte_pkg::*;
	logic            valid;
	logic            ready;
	logic [CmdW-1:0] command;
	logic [IdxW-1:0] cell_index;
	logic [CntW-1:0] fill_count;
	logic [ValW-1:0] cell_value;
	logic [RowW-1:0] cursor_row;
	logic [ColW-1:0] cursor_col;
	logic            last_of_run;

	modport source(output valid, output command, output cell_index, output fill_count,
		output cell_value, output cursor_row, output cursor_col, output last_of_run,
		input ready);
	modport sink(input valid, input command, input cell_index, input fill_count,
		input cell_value, input cursor_row, input cursor_col, input last_of_run,
		output ready);
endinterface

/* rtl/atte_mac.sv */
// ----------------------------------------------------------------------------
// Shared multiply-add unit
// Registered a * b + c, used for cell indexes, fill spans and decimal digits.
// ----------------------------------------------------------------------------
module atte_mac (
	input  logic                         clk,
	input  logic [atte_pkg::ArgW-1:0]    a,
	input  logic [7:0]                   b,
	input  logic [atte_pkg::ArgW-1:0]    c,
	output logic [atte_pkg::MacW-1:0]    r_q
);
	import atte_pkg::*;

	// One product and one add per cycle, result registered.
	always_ff @(posedge clk) begin
		r_q <= MacW'(a * b) + MacW'(c);
	end
endmodule

/* rtl/atte_sgr.sv */
// ----------------------------------------------------------------------------
// Select graphic rendition step
// Applies one SGR argument to the colour attribute and bold flag.
// ----------------------------------------------------------------------------
module atte_sgr (
	input  logic [15:0]               attr,
	input  logic                      bold,
	input  logic [atte_pkg::ArgW-1:0] arg,
	input  logic [15:0]               dflt,
	output logic [15:0]               attr_nx,
	output logic                      bold_nx
);
	import atte_pkg::*;

	logic [ArgW-1:0] fg_off;
	logic [ArgW-1:0] bg_off;

	assign fg_off = arg - ArgW'(30);
	assign bg_off = arg - ArgW'(40);

	// Only the codes below ten and the two colour decades have any effect.
	always_comb begin
		attr_nx = attr;
		bold_nx = bold;
		if (arg == ArgW'(0)) begin
			attr_nx = dflt;
			bold_nx = 1'b0;
		end else if (arg == ArgW'(1)) begin
			bold_nx = 1'b1;
		end else if (arg == ArgW'(2)) begin
			bold_nx = 1'b0;
		end else if (arg == ArgW'(7)) begin
			attr_nx = {attr[11:8], attr[15:12], 8'h00};
		end else if (arg >= ArgW'(30) && arg <= ArgW'(37)) begin
			attr_nx[11:8] = COLOUR_MAP[fg_off[2:0]];
		end else if (arg >= ArgW'(40) && arg <= ArgW'(47)) begin
			attr_nx[15:12] = COLOUR_MAP[bg_off[2:0]];
		end
	end
endmodule

/* rtl/ansi_text_terminal_engine.sv */
// Bytes: a byte that is ignored (NUL or console disabled) is taken and dropped
// in the idle state; any other byte is decoded and its results handed out
// before the next byte is taken, so a stalled output holds the input too. An
// SGR sequence walks each stored argument (up to eight) through the SGR step;
// the sequencer uses the shared multiply-add unit for indexes, spans and digits.
// Reset: asynchronous, active low; cursor, parser and arguments clear,
// attribute and configuration registers return to their defaults at once.
// ----------------------------------------------------------------------------
// ANSI text terminal engine
// Parses a console byte stream and issues write, fill, scroll and cursor
// commands for a text-cell store.
// ----------------------------------------------------------------------------
module ansi_text_terminal_engine (
	input  logic        clk,
	input  logic        arst_n,
	atte_in_if.sink     in_ch,
	atte_out_if.source  out_ch,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import atte_pkg::*;

	typedef enum logic [12:0] {
		ST_IDLE    = 13'b0000000000001,
		ST_CLAMP   = 13'b0000000000010,
		ST_DECODE  = 13'b0000000000100,
		ST_DIGIT   = 13'b0000000001000,
		ST_WRITE   = 13'b0000000010000,
		ST_SCRMUL  = 13'b0000000100000,
		ST_SCRPUSH = 13'b0000001000000,
		ST_KPUSH   = 13'b0000010000000,
		ST_JCNT    = 13'b0000100000000,
		ST_JPUSH   = 13'b0001000000000,
		ST_SGR     = 13'b0010000000000,
		ST_FIN     = 13'b0100000000000,
		ST_EMIT    = 13'b1000000000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [7:0]  columns_q;
	logic [6:0]  rows_q;
	logic [15:0] defattr_q;
	logic        enable_q;

	// Terminal state.
	logic [RowW-1:0]    row_q, srow_q;
	logic [ColW-1:0]    col_q, scol_q;
	logic [15:0]        attr_q;
	logic               bold_q;
	logic [1:0]         mode_q;
	logic [ArgW-1:0]    args_q [MaxArgs];
	logic [ArgIdxW-1:0] cnt_q, sgr_i_q;
	logic [7:0]         c_q;
	logic [CntW-1:0]    jcnt_q;

	// Pending results and output register.
	res_t            res_q [2];
	logic [1:0]      nres_q;
	logic            emit_i_q;
	logic            out_valid_q;
	res_t            out_q;
	logic            out_last_q;
	logic [RowW-1:0] out_row_q;
	logic [ColW-1:0] out_col_q;

	logic [ColsW-1:0] cols_u;
	logic [RowsW-1:0] rows_u;
	logic [ArgIdxW-1:0] rd_idx;
	logic [ArgW-1:0]  arg_rd, a0, a1, k, a0p, a1p;
	logic [ArgW-1:0]  alu_a, alu_c;
	logic [7:0]       alu_b;
	logic [MacW-1:0]  alu_q;
	logic [15:0]      sgr_attr;
	logic             sgr_bold;
	logic             is_digit;
	logic             push_en;
	res_t             push_d;
	logic [7:0]       ch;
	logic [15:0]      wval;
	logic             out_free;
	logic [RowsW-1:0] row_inc;
	logic [ColsW-1:0] col_inc;
	logic [ArgW:0]    sum_row, sum_col;

	// Screen size in use, clamped into the supported range.
	always_comb begin
		cols_u = (columns_q == 8'd0) ? ColsW'(1) :
			(ColsW'(columns_q) > ColsW'(MaxColumns)) ? ColsW'(MaxColumns) : ColsW'(columns_q);
		rows_u = (rows_q == 7'd0) ? RowsW'(1) :
			(RowsW'(rows_q) > RowsW'(MaxRows)) ? RowsW'(MaxRows) : RowsW'(rows_q);
	end

	// Indexed argument read port, shared by digit collection and the SGR walk.
	assign rd_idx = (state_q == ST_SGR) ? sgr_i_q : cnt_q;
	assign arg_rd = args_q[rd_idx];
	assign a0     = args_q[0];
	assign a1     = args_q[1];
	assign k      = (a0 == ArgW'(0)) ? ArgW'(1) : a0;
	assign a0p    = k;
	assign a1p    = (a1 == ArgW'(0)) ? ArgW'(1) : a1;
	assign is_digit = (c_q >= CH_ZERO) && (c_q <= CH_NINE);
	assign row_inc = RowsW'(row_q) + RowsW'(1);
	assign col_inc = ColsW'(col_q) + ColsW'(1);
	assign sum_row = (ArgW+1)'(k) + (ArgW+1)'(row_q);
	assign sum_col = (ArgW+1)'(k) + (ArgW+1)'(col_q);

	// Cell value for a plain write.
	always_comb begin
		ch   = (c_q < CH_SPACE) ? CH_QMARK : c_q;
		wval = attr_q | {8'h00, ch};
		if (bold_q) begin
			wval = wval + BoldAdd;
		end
	end

	// Operand selection for the shared multiply-add unit.
	always_comb begin
		alu_a = ArgW'(row_q);
		alu_b = 8'(cols_u);
		alu_c = ArgW'(col_q);
		unique case (state_q)
			ST_DECODE: begin
				if (mode_q == MODE_CSI && is_digit) begin
					alu_a = arg_rd;
					alu_b = 8'd10;
					alu_c = ArgW'(c_q - CH_ZERO);
				end else if (mode_q == MODE_CSI && c_q == CH_ED) begin
					alu_a = ArgW'(cols_u);
					alu_c = '0;
					if (a0 == ArgW'(0)) begin
						alu_b = 8'(row_q);
					end else if (a0 == ArgW'(1)) begin
						alu_b = 8'(rows_u - RowsW'(row_q));
					end else begin
						alu_b = 8'(rows_u);
					end
				end
			end
			ST_SCRMUL: begin
				alu_a = ArgW'(rows_u - RowsW'(1));
				alu_c = '0;
			end
			ST_JCNT: begin
				alu_c = '0;
			end
			default: begin
			end
		endcase
	end

	atte_mac u_mac (
		.clk (clk),
		.a   (alu_a),
		.b   (alu_b),
		.c   (alu_c),
		.r_q (alu_q)
	);

	atte_sgr u_sgr (
		.attr    (attr_q),
		.bold    (bold_q),
		.arg     (arg_rd),
		.dflt    (defattr_q),
		.attr_nx (sgr_attr),
		.bold_nx (sgr_bold)
	);

	// Result pushed into the pending list in this cycle.
	always_comb begin
		push_en = 1'b0;
		push_d  = '{cmd: CMD_UPDATE, idx: '0, cnt: '0, val: '0};
		unique case (state_q)
			ST_WRITE: begin
				push_en = 1'b1;
				push_d  = '{cmd: CMD_WRITE, idx: alu_q[IdxW-1:0], cnt: CntW'(1), val: wval};
			end
			ST_SCRPUSH: begin
				push_en = 1'b1;
				push_d  = '{cmd: CMD_SCROLL, idx: alu_q[IdxW-1:0], cnt: CntW'(cols_u),
					val: defattr_q};
			end
			ST_KPUSH: begin
				push_en = 1'b1;
				push_d  = '{cmd: CMD_FILL, idx: alu_q[IdxW-1:0],
					cnt: CntW'(cols_u - ColsW'(col_q)), val: attr_q};
			end
			ST_JPUSH: begin
				push_en = 1'b1;
				push_d  = '{cmd: CMD_FILL,
					idx: (a0 == ArgW'(1)) ? alu_q[IdxW-1:0] : IdxW'(0),
					cnt: jcnt_q, val: attr_q};
			end
			ST_FIN: begin
				push_en = (nres_q == 2'd0);
			end
			default: begin
			end
		endcase
	end

	assign out_free = !out_valid_q || out_ch.ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= 8'd80;
			rows_q    <= 7'd25;
			defattr_q <= ResetAttribute;
			enable_q  <= 1'b1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_COLUMNS: columns_q <= cfg_data[7:0];
				REG_ROWS:    rows_q    <= cfg_data[6:0];
				REG_DEFATTR: defattr_q <= cfg_data;
				REG_ENABLE:  enable_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Pending result slots, byte latch and erase-display count.
	always_ff @(posedge clk) begin
		if (push_en) begin
			res_q[nres_q[0]] <= push_d;
		end
		if (in_ch.valid && in_ch.ready) begin
			c_q <= in_ch.char_byte;
		end
		if (state_q == ST_JCNT) begin
			jcnt_q <= alu_q[CntW-1:0];
		end
	end

	// Sequencer and terminal state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= '0;
			col_q       <= '0;
			srow_q      <= '0;
			scol_q      <= '0;
			attr_q      <= ResetAttribute;
			bold_q      <= 1'b0;
			mode_q      <= MODE_TEXT;
			cnt_q       <= '0;
			sgr_i_q     <= '0;
			nres_q      <= '0;
			emit_i_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '{cmd: CMD_UPDATE, idx: '0, cnt: '0, val: '0};
			out_last_q  <= 1'b0;
			out_row_q   <= '0;
			out_col_q   <= '0;
			for (int i = 0; i < MaxArgs; i++) begin
				args_q[i] <= '0;
			end
		end else begin
			if (push_en) begin
				nres_q <= nres_q + 2'd1;
			end
			// The emit state reloads the output register itself whenever it is taken.
			if (out_valid_q && out_ch.ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						nres_q   <= '0;
						emit_i_q <= 1'b0;
						if (enable_q && in_ch.char_byte != CH_NUL) begin
							state_q <= ST_CLAMP;
						end
					end
				end
				ST_CLAMP: begin
					if (RowsW'(row_q) >= rows_u) begin
						row_q <= RowW'(rows_u - RowsW'(1));
					end
					if (ColsW'(col_q) >= cols_u) begin
						col_q <= ColW'(cols_u - ColsW'(1));
					end
					state_q <= ST_DECODE;
				end
				ST_DECODE: begin
					if (mode_q == MODE_CSI) begin
						if (is_digit) begin
							state_q <= ST_DIGIT;
						end else if (c_q == CH_SEMI) begin
							if (cnt_q != ArgIdxW'(MaxArgs - 1)) begin
								cnt_q <= cnt_q + ArgIdxW'(1);
								args_q[cnt_q + ArgIdxW'(1)] <= '0;
							end
							state_q <= ST_IDLE;
						end else begin
							mode_q  <= MODE_TEXT;
							state_q <= ST_FIN;
							unique case (c_q)
								CH_SGR: begin
									sgr_i_q <= '0;
									state_q <= ST_SGR;
								end
								CH_UP: begin
									row_q <= (k >= ArgW'(row_q)) ? '0 : row_q - RowW'(k);
								end
								CH_DOWN: begin
									row_q <= (sum_row >= (ArgW+1)'(rows_u - RowsW'(1))) ?
										RowW'(rows_u - RowsW'(1)) : row_q + RowW'(k);
								end
								CH_RIGHT: begin
									col_q <= (sum_col >= (ArgW+1)'(cols_u - ColsW'(1))) ?
										ColW'(cols_u - ColsW'(1)) : col_q + ColW'(k);
								end
								CH_LEFT: begin
									col_q <= (k >= ArgW'(col_q)) ? '0 : col_q - ColW'(k);
								end
								CH_EL: begin
									state_q <= ST_KPUSH;
								end
								CH_ED: begin
									state_q <= ST_JCNT;
								end
								CH_POS: begin
									row_q <= (a0p - ArgW'(1) >= ArgW'(rows_u)) ?
										RowW'(rows_u - RowsW'(1)) : RowW'(a0p - ArgW'(1));
									col_q <= (a1p - ArgW'(1) >= ArgW'(cols_u)) ?
										ColW'(cols_u - ColsW'(1)) : ColW'(a1p - ArgW'(1));
								end
								CH_SAVE: begin
									srow_q <= row_q;
									scol_q <= col_q;
								end
								CH_REST: begin
									row_q <= (RowsW'(srow_q) >= rows_u) ?
										RowW'(rows_u - RowsW'(1)) : srow_q;
									col_q <= (ColsW'(scol_q) >= cols_u) ?
										ColW'(cols_u - ColsW'(1)) : scol_q;
								end
								default: begin
								end
							endcase
						end
					end else if (mode_q == MODE_ESC && c_q == CH_LBR) begin
						mode_q  <= MODE_CSI;
						state_q <= ST_IDLE;
					end else begin
						mode_q <= MODE_TEXT;
						if (c_q == CH_ESC) begin
							mode_q <= MODE_ESC;
							cnt_q  <= '0;
							for (int i = 0; i < MaxArgs; i++) begin
								args_q[i] <= '0;
							end
							state_q <= ST_IDLE;
						end else if (c_q == CH_LF) begin
							col_q <= '0;
							if (row_inc >= rows_u) begin
								state_q <= ST_SCRMUL;
							end else begin
								row_q   <= row_inc[RowW-1:0];
								state_q <= ST_FIN;
							end
						end else begin
							state_q <= ST_WRITE;
						end
					end
				end
				ST_DIGIT: begin
					args_q[cnt_q] <= (alu_q > MacW'(ArgMax)) ? ArgMax : alu_q[ArgW-1:0];
					state_q <= ST_IDLE;
				end
				ST_WRITE: begin
					state_q <= ST_FIN;
					if (col_inc >= cols_u) begin
						col_q <= '0;
						if (row_inc >= rows_u) begin
							state_q <= ST_SCRMUL;
						end else begin
							row_q <= row_inc[RowW-1:0];
						end
					end else begin
						col_q <= col_inc[ColW-1:0];
					end
				end
				ST_SCRMUL: begin
					row_q   <= RowW'(rows_u - RowsW'(1));
					state_q <= ST_SCRPUSH;
				end
				ST_SCRPUSH: begin
					state_q <= ST_FIN;
				end
				ST_KPUSH: begin
					state_q <= ST_FIN;
				end
				ST_JCNT: begin
					state_q <= (a0 > ArgW'(2)) ? ST_FIN : ST_JPUSH;
				end
				ST_JPUSH: begin
					state_q <= ST_FIN;
				end
				ST_SGR: begin
					attr_q <= sgr_attr;
					bold_q <= sgr_bold;
					if (sgr_i_q == cnt_q) begin
						state_q <= ST_FIN;
					end else begin
						sgr_i_q <= sgr_i_q + ArgIdxW'(1);
					end
				end
				ST_FIN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q       <= res_q[emit_i_q];
						out_last_q  <= ({1'b0, emit_i_q} + 2'd1 == nres_q);
						out_row_q   <= row_q;
						out_col_q   <= col_q;
						emit_i_q    <= 1'b1;
						if ({1'b0, emit_i_q} + 2'd1 == nres_q) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Ports.
	assign in_ch.ready        = (state_q == ST_IDLE);
	assign out_ch.valid       = out_valid_q;
	assign out_ch.command     = out_q.cmd;
	assign out_ch.cell_index  = out_q.idx;
	assign out_ch.fill_count  = out_q.cnt;
	assign out_ch.cell_value  = out_q.val;
	assign out_ch.cursor_row  = out_row_q;
	assign out_ch.cursor_col  = out_col_q;
	assign out_ch.last_of_run = out_last_q;

	// The cursor lies inside the screen when a byte is decoded.
	a_cursor_in_screen: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECODE) |-> (RowsW'(row_q) < rows_u && ColsW'(col_q) < cols_u))
		else $error("cursor outside screen at decode");

	// Emission only ever runs with one or two pending results.
	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (nres_q == 2'd1 || nres_q == 2'd2))
		else $error("bad pending result count");

	// The SGR walk never passes the last collected argument.
	a_sgr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SGR) |-> (sgr_i_q <= cnt_q))
		else $error("SGR walk beyond argument count");

	// The final result of a byte is flagged as last and the sequencer returns to idle.
	a_last_before_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && $past(state_q) == ST_EMIT && out_free &&
		{1'b0, emit_i_q} + 2'd1 == nres_q) |=> (out_last_q && state_q == ST_IDLE))
		else $error("final result not flagged as last");
endmodule

/* tb/sv/atte_scoreboard.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terminal command scoreboard
// Predicts the cell-store commands of the terminal engine for each accepted
// byte and checks every output beat against the oldest expected command.
// ----------------------------------------------------------------------------
import atte_pkg::*;

class atte_scoreboard;

	typedef struct {
		cmd_t        cmd;
		logic [12:0] idx;
		logic [13:0] cnt;
		logic [15:0] val;
		logic [5:0]  row;
		logic [6:0]  col;
		logic        last;
	} term_cmd_t;

	// Configuration copy.
	int unsigned columns_reg, rows_reg, defattr_reg, enable_reg;
	// Terminal state.
	int unsigned row_pos, col_pos, saved_row, saved_col, attribute, bold, mode, arg_cnt;
	int unsigned arg_val[MaxArgs];
	term_cmd_t pending_cmds[$];
	term_cmd_t byte_cmds[$];
	int errors;

	function new();
		errors = 0;
		columns_reg = 80;
		rows_reg = 25;
		defattr_reg = 16'h1700;
		enable_reg = 1;
		row_pos = 0;
		col_pos = 0;
		saved_row = 0;
		saved_col = 0;
		attribute = 16'h1700;
		bold = 0;
		mode = 0;
		arg_cnt = 0;
		foreach (arg_val[i]) arg_val[i] = 0;
	endfunction

	function void write_reg(logic [1:0] index, logic [15:0] data);
		case (index)
			REG_COLUMNS: columns_reg = data[7:0];
			REG_ROWS:    rows_reg = data[6:0];
			REG_DEFATTR: defattr_reg = data;
			default:     enable_reg = data[0];
		endcase
	endfunction

	function int unsigned cols_used();
		if (columns_reg < 1) return 1;
		if (columns_reg > MaxColumns) return MaxColumns;
		return columns_reg;
	endfunction

	function int unsigned rows_used();
		if (rows_reg < 1) return 1;
		if (rows_reg > MaxRows) return MaxRows;
		return rows_reg;
	endfunction

	function void emit(cmd_t cmd, int unsigned idx, int unsigned cnt, int unsigned val);
		term_cmd_t t;
		if (byte_cmds.size() >= 2) return;
		t.cmd = cmd;
		t.idx = idx[12:0];
		t.cnt = cnt[13:0];
		t.val = val[15:0];
		t.row = 0;
		t.col = 0;
		t.last = 0;
		byte_cmds.push_back(t);
	endfunction

	function void scroll();
		row_pos = rows_used() - 1;
		emit(CMD_SCROLL, (rows_used() - 1) * cols_used(), cols_used(), defattr_reg);
	endfunction

	function void text_byte(int unsigned c);
		int unsigned v;
		if (c == CH_ESC) begin
			mode = MODE_ESC;
			foreach (arg_val[i]) arg_val[i] = 0;
			arg_cnt = 0;
			return;
		end
		if (c == CH_LF) begin
			row_pos++;
			col_pos = 0;
			if (row_pos >= rows_used()) scroll();
			else emit(CMD_UPDATE, 0, 0, 0);
			return;
		end
		if (c < CH_SPACE) c = CH_QMARK;
		v = (c | attribute) & 16'hFFFF;
		if (bold) v = (v + BoldAdd) & 16'hFFFF;
		emit(CMD_WRITE, row_pos * cols_used() + col_pos, 1, v);
		col_pos++;
		if (col_pos >= cols_used()) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= rows_used()) scroll();
		end
	endfunction

	function void graphics(int unsigned v);
		int unsigned tens, unit, a;
		tens = v / 10;
		unit = v % 10;
		if (tens == 0) begin
			if (unit == 0) begin
				attribute = defattr_reg;
				bold = 0;
			end else if (unit == 1) begin
				bold = 1;
			end else if (unit == 2) begin
				bold = 0;
			end else if (unit == 7) begin
				a = attribute >> 4;
				a |= (a & 8'hF0) << 8;
				attribute = a & 16'hFF00;
			end
		end else if (tens == 3 && unit < 8) begin
			attribute = (attribute & 16'hF0FF) | (int'(COLOUR_MAP[unit]) << 8);
		end else if (tens == 4 && unit < 8) begin
			attribute = (attribute & 16'h0FFF) | (int'(COLOUR_MAP[unit]) << 12);
		end
	endfunction

	function void finish_seq(int unsigned letter);
		int unsigned cols, rows, a0, a1, k;
		cols = cols_used();
		rows = rows_used();
		a0 = arg_val[0];
		a1 = arg_val[1];
		k = (a0 != 0) ? a0 : 1;
		case (letter)
			CH_SGR: for (int i = 0; i <= arg_cnt && i < MaxArgs; i++) graphics(arg_val[i]);
			CH_UP: row_pos = (k >= row_pos) ? 0 : row_pos - k;
			CH_DOWN: row_pos = (k + row_pos >= rows - 1) ? rows - 1 : row_pos + k;
			CH_RIGHT: col_pos = (k + col_pos >= cols - 1) ? cols - 1 : col_pos + k;
			CH_LEFT: col_pos = (k >= col_pos) ? 0 : col_pos - k;
			CH_EL: emit(CMD_FILL, row_pos * cols + col_pos, cols - col_pos, attribute);
			CH_ED: begin
				if (a0 == 0) emit(CMD_FILL, 0, cols * row_pos, attribute);
				else if (a0 == 1) emit(CMD_FILL, row_pos * cols, cols * (rows - row_pos),
					attribute);
				else if (a0 == 2) emit(CMD_FILL, 0, cols * rows, attribute);
			end
			CH_POS: begin
				if (a0 == 0) a0 = 1;
				if (a1 == 0) a1 = 1;
				row_pos = (a0 - 1 >= rows) ? rows - 1 : a0 - 1;
				col_pos = (a1 - 1 >= cols) ? cols - 1 : a1 - 1;
			end
			CH_SAVE: begin
				saved_row = row_pos;
				saved_col = col_pos;
			end
			CH_REST: begin
				row_pos = saved_row;
				col_pos = saved_col;
				if (row_pos >= rows) row_pos = rows - 1;
				if (col_pos >= cols) col_pos = cols - 1;
			end
			default: ;
		endcase
		if (byte_cmds.size() == 0) emit(CMD_UPDATE, 0, 0, 0);
	endfunction

	// Notes one accepted byte and queues the commands it should cause.
	function void note_byte(logic [7:0] b);
		int unsigned c, idx, v;
		c = b;
		byte_cmds.delete();
		if (enable_reg == 0 || c == 0) return;
		if (row_pos >= rows_used()) row_pos = rows_used() - 1;
		if (col_pos >= cols_used()) col_pos = cols_used() - 1;
		if (mode == MODE_CSI) begin
			if (c >= CH_ZERO && c <= CH_NINE) begin
				idx = (arg_cnt < MaxArgs) ? arg_cnt : MaxArgs - 1;
				v = arg_val[idx] * 10 + (c - CH_ZERO);
				arg_val[idx] = (v > 65535) ? 65535 : v;
			end else if (c == CH_SEMI) begin
				if (arg_cnt + 1 < MaxArgs) begin
					arg_cnt++;
					arg_val[arg_cnt] = 0;
				end
			end else begin
				mode = MODE_TEXT;
				finish_seq(c);
			end
		end else if (mode == MODE_ESC && c == CH_LBR) begin
			mode = MODE_CSI;
		end else begin
			mode = MODE_TEXT;
			text_byte(c);
		end
		foreach (byte_cmds[i]) begin
			byte_cmds[i].row = row_pos[5:0];
			byte_cmds[i].col = col_pos[6:0];
			byte_cmds[i].last = (i == byte_cmds.size() - 1);
			pending_cmds.push_back(byte_cmds[i]);
		end
	endfunction

	// Checks one output beat against the oldest expected command.
	function void check_cmd(logic [1:0] cmd, logic [12:0] idx, logic [13:0] cnt,
			logic [15:0] val, logic [5:0] row, logic [6:0] col, logic last);
		term_cmd_t e;
		if (pending_cmds.size() == 0) begin
			$error("unexpected command beat: command %0d", cmd);
			errors++;
			return;
		end
		e = pending_cmds.pop_front();
		if (cmd !== e.cmd) begin
			$error("command: expected %0d, actual %0d", e.cmd, cmd);
			errors++;
		end
		if (idx !== e.idx) begin
			$error("cell_index: expected %0d, actual %0d", e.idx, idx);
			errors++;
		end
		if (cnt !== e.cnt) begin
			$error("fill_count: expected %0d, actual %0d", e.cnt, cnt);
			errors++;
		end
		if (val !== e.val) begin
			$error("cell_value: expected %h, actual %h", e.val, val);
			errors++;
		end
		if (row !== e.row) begin
			$error("cursor_row: expected %0d, actual %0d", e.row, row);
			errors++;
		end
		if (col !== e.col) begin
			$error("cursor_col: expected %0d, actual %0d", e.col, col);
			errors++;
		end
		if (last !== e.last) begin
			$error("last_of_run: expected %0d, actual %0d", e.last, last);
			errors++;
		end
	endfunction
endclass

/* tb/sv/ansi_text_terminal_engine_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ANSI text terminal engine testbench
// Drives directed and random byte streams (text, escape sequences, control
// bytes and noise) under several screen settings with random stalls on both
// channels, and checks every command beat against a behavioural predictor.
// ----------------------------------------------------------------------------
module ansi_text_terminal_engine_tb;
	import atte_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          stim_done;

	atte_in_if  in_ch ();
	atte_out_if out_ch ();

	atte_scoreboard terminal_sb = new();

	ansi_text_terminal_engine DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Clock generation.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Output monitor and random back-pressure.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			terminal_sb.check_cmd(out_ch.command, out_ch.cell_index, out_ch.fill_count,
				out_ch.cell_value, out_ch.cursor_row, out_ch.cursor_col, out_ch.last_of_run);
	end

	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Sends one byte: presents it from a falling edge, waits until the block is
	// ready, and returns at the falling edge after the accepting rising edge.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.char_byte <= b;
		while (!in_ch.ready) @(negedge clk);
		@(posedge clk);
		terminal_sb.note_byte(b);
		@(negedge clk);
	endtask

	task automatic send_csi(input string body);
		send_byte(CH_ESC);
		send_byte(CH_LBR);
		foreach (body[i]) send_byte(body[i]);
	endtask

	// Waits for all expected commands, then lets the block settle.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (terminal_sb.pending_cmds.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
		cfg_write <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		terminal_sb.write_reg(index, data);
		@(negedge clk);
	endtask

	task automatic send_number(input int n);
		string s;
		s.itoa(n);
		foreach (s[i]) send_byte(s[i]);
	endtask

	// One random item: a well-formed sequence, plain text or noise.
	task automatic random_item();
		int kind;
		int nargs;
		logic [7:0] finals[10];
		finals = '{CH_SGR, CH_UP, CH_DOWN, CH_RIGHT, CH_LEFT, CH_EL, CH_ED, CH_POS,
			CH_SAVE, CH_REST};
		kind = $urandom_range(99);
		if (kind < 45) begin
			send_byte(CH_ESC);
			send_byte(CH_LBR);
			nargs = $urandom_range(3);
			if ($urandom_range(19) == 0) nargs = $urandom_range(11);
			for (int i = 0; i < nargs; i++) begin
				if (i != 0) send_byte(CH_SEMI);
				case ($urandom_range(4))
					0: send_number($urandom_range(9));
					1: send_number(30 + $urandom_range(9));
					2: send_number(40 + $urandom_range(9));
					3: send_number($urandom_range(70));
					default: if ($urandom_range(3) != 0) send_number($urandom_range(9));
				endcase
			end
			if ($urandom_range(9) == 0) send_byte(8'($urandom_range(8'h40, 8'h7E)));
			else send_byte(finals[$urandom_range(9)]);
		end else if (kind < 80) begin
			send_byte(8'($urandom_range(8'h20, 8'hFF)));
		end else if (kind < 90) begin
			send_byte(CH_LF);
		end else begin
			send_byte(8'($urandom_range(255)));
		end
	endtask

	task automatic random_phase(input int n);
		for (int i = 0; i < n; i++) random_item();
		drain();
	endtask

	// Main stimulus.
	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_COLUMNS;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.char_byte = '0;
		out_ch.ready = 1'b0;
		send_idle_pct = 38;
		recv_idle_pct = 65;
		stim_done = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: extremes, every sequence but cursor down, special cases.
		send_byte(8'hFF);
		send_byte(CH_NUL);
		send_byte(8'h01);
		send_byte(CH_LF);
		send_csi("1;7;31;44;38;49m");
		send_byte(8'h41);
		send_csi("99;99f");
		send_byte(8'h42);
		send_csi("2J");
		send_csi("1;2;3;4;5;6;7;8;9;0m");
		send_csi("99999A");
		send_csi("sB");
		send_csi("0;0f");
		send_csi("K");
		send_csi("1J");
		send_csi("J");
		send_csi("5J");
		send_csi("3C");
		send_csi("D");
		send_csi("uz");
		send_byte(CH_ESC);
		send_byte(8'h58);
		drain();

		// Small screen with save then shrink.
		write_reg(REG_COLUMNS, 16'd0);
		write_reg(REG_ROWS, 16'd0);
		write_reg(REG_DEFATTR, 16'hFFFF);
		random_phase(30);
		write_reg(REG_ENABLE, 16'd0);
		send_byte(8'h41);
		send_byte(CH_LF);
		drain();
		write_reg(REG_ENABLE, 16'd1);
		write_reg(REG_COLUMNS, 16'd255);
		write_reg(REG_ROWS, 16'd127);
		write_reg(REG_DEFATTR, 16'h0000);
		random_phase(140);
		write_reg(REG_COLUMNS, 16'd5);
		write_reg(REG_ROWS, 16'd3);
		random_phase(110);

		send_idle_pct = 65;
		recv_idle_pct = 38;
		write_reg(REG_COLUMNS, 16'd128);
		write_reg(REG_ROWS, 16'd64);
		write_reg(REG_DEFATTR, 16'h5A3C);
		random_phase(120);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_COLUMNS, 16'd80);
		write_reg(REG_ROWS, 16'd25);
		random_phase(120);

		if (terminal_sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog.
	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end
endmodule

/* filelist.f */
rtl/atte_pkg.sv
rtl/atte_in_if.sv
rtl/atte_out_if.sv
rtl/atte_mac.sv
rtl/atte_sgr.sv
rtl/ansi_text_terminal_engine.sv
tb/sv/atte_scoreboard.sv
tb/sv/ansi_text_terminal_engine_tb.sv
